// File: sv/brle_pkg.sv
// Shared types and constants of the bitonal run-length encoder.
package brle_pkg;

	localparam int unsigned RAW_W    = 8;
	localparam int unsigned CODE_W   = 8;
	localparam int unsigned WIDTH_W  = 16;
	localparam int unsigned PIX_CNT_W = 3;

	localparam logic [PIX_CNT_W-1:0] LAST_PIXEL = 3'd7;

	localparam logic [WIDTH_W-1:0] SHORT_LIMIT = 16'd192;
	localparam logic [WIDTH_W-1:0] SPLIT_LIMIT = 16'd16384;
	localparam logic [WIDTH_W-1:0] SPLIT_CHUNK = 16'd16383;
	localparam logic [1:0]         LONG_PREFIX = 2'b11;
	localparam logic [CODE_W-1:0]  SPLIT_BYTE  = 8'hFF;
	localparam logic [CODE_W-1:0]  ZERO_RUN    = 8'h00;

	typedef struct packed {
		logic load;
		logic px_step;
		logic emit_go;
		logic flush_go;
	} brle_cmd_t;

	typedef struct packed {
		logic chg;
		logic rowend;
		logic last_px;
		logic run_last;
		logic pend_end;
		logic hold_valid;
		logic out_free;
	} brle_sts_t;

endpackage

// File: sv/brle_if.sv
// Valid/ready channel interfaces for raster input and code output.
interface brle_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] raw_byte;

	modport source (output valid, output raw_byte, input ready);
	modport sink (input valid, input raw_byte, output ready);
endinterface

interface brle_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] code_byte;
	logic       end_of_row;
	logic       last_of_item;

	modport source (output valid, output code_byte, output end_of_row, output last_of_item,
		input ready);
	modport sink (input valid, input code_byte, input end_of_row, input last_of_item,
		output ready);
endinterface

// File: sv/brle_datapath.sv
// Pixel scan, run counting, run-length code generation and output register.
module brle_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [brle_pkg::WIDTH_W-1:0]   cfg_wdata,
	input  logic [brle_pkg::RAW_W-1:0]     raw_byte,
	input  brle_pkg::brle_cmd_t            cmd,
	output brle_pkg::brle_sts_t            sts,
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic [brle_pkg::CODE_W-1:0]    code_byte,
	output logic                           end_of_row,
	output logic                           last_of_item
);
	import brle_pkg::*;

	typedef enum logic [2:0] {PH_SHORT, PH_HI, PH_LO, PH_SP0, PH_SP1, PH_SP2} phase_t;

	function automatic phase_t first_phase(input logic [WIDTH_W-1:0] len);
		phase_t ph;
		if (len >= SPLIT_LIMIT) begin
			ph = PH_SP0;
		end else if (len < SHORT_LIMIT) begin
			ph = PH_SHORT;
		end else begin
			ph = PH_HI;
		end
		return ph;
	endfunction

	logic [WIDTH_W-1:0]   width_q;
	logic [WIDTH_W-1:0]   col_q;
	logic [WIDTH_W-1:0]   run_q;
	logic                 colour_q;
	logic [RAW_W-1:0]     sh_q;
	logic [PIX_CNT_W-1:0] cnt_q;
	logic [WIDTH_W-1:0]   len_q;
	phase_t               phase_q;
	logic                 eor_q;
	logic                 pend_q;
	logic                 hold_valid_q;
	logic [CODE_W-1:0]    hold_byte_q;
	logic                 hold_eor_q;
	logic                 out_valid_q;
	logic [CODE_W-1:0]    out_byte_q;
	logic                 out_eor_q;
	logic                 out_last_q;

	logic                 px;
	logic                 chg;
	logic                 rowend;
	logic [WIDTH_W-1:0]   w_eff;
	logic [WIDTH_W-1:0]   run_plus;
	logic [WIDTH_W-1:0]   len_split;
	logic [CODE_W-1:0]    cur_byte;
	logic                 run_last;
	logic                 out_free;
	logic                 push;

	assign px        = sh_q[RAW_W-1];
	assign chg       = px != colour_q;
	assign w_eff     = (width_q == '0) ? WIDTH_W'(1) : width_q;
	assign rowend    = ({1'b0, col_q} + (WIDTH_W+1)'(1)) >= {1'b0, w_eff};
	assign run_plus  = run_q + WIDTH_W'(1);
	assign len_split = len_q - SPLIT_CHUNK;
	assign run_last  = (phase_q == PH_SHORT) || (phase_q == PH_LO);
	assign out_free  = !out_valid_q || out_ready;
	assign push      = hold_valid_q && (cmd.emit_go || cmd.flush_go);

	always_comb begin
		unique case (phase_q)
			PH_SHORT: cur_byte = len_q[CODE_W-1:0];
			PH_HI:    cur_byte = {LONG_PREFIX, len_q[13:8]};
			PH_LO:    cur_byte = len_q[CODE_W-1:0];
			PH_SP0:   cur_byte = SPLIT_BYTE;
			PH_SP1:   cur_byte = SPLIT_BYTE;
			PH_SP2:   cur_byte = ZERO_RUN;
			default:  cur_byte = ZERO_RUN;
		endcase
	end

	always_comb begin
		sts.chg        = chg;
		sts.rowend     = rowend;
		sts.last_px    = cnt_q == LAST_PIXEL;
		sts.run_last   = run_last;
		sts.pend_end   = pend_q;
		sts.hold_valid = hold_valid_q;
		sts.out_free   = out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q      <= WIDTH_W'(1);
			col_q        <= '0;
			run_q        <= '0;
			colour_q     <= 1'b0;
			sh_q         <= '0;
			cnt_q        <= '0;
			len_q        <= '0;
			phase_q      <= PH_SHORT;
			eor_q        <= 1'b0;
			pend_q       <= 1'b0;
			hold_valid_q <= 1'b0;
			hold_byte_q  <= '0;
			hold_eor_q   <= 1'b0;
			out_valid_q  <= 1'b0;
			out_byte_q   <= '0;
			out_eor_q    <= 1'b0;
			out_last_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				width_q <= cfg_wdata;
			end
			if (cmd.load) begin
				sh_q  <= raw_byte;
				cnt_q <= '0;
			end
			if (cmd.px_step) begin
				sh_q  <= {sh_q[RAW_W-2:0], 1'b0};
				cnt_q <= cnt_q + PIX_CNT_W'(1);
				col_q <= rowend ? '0 : col_q + WIDTH_W'(1);
				if (chg) begin
					len_q    <= run_q;
					phase_q  <= first_phase(run_q);
					eor_q    <= 1'b0;
					pend_q   <= rowend;
					run_q    <= WIDTH_W'(1);
					colour_q <= px;
				end else if (rowend) begin
					len_q    <= run_plus;
					phase_q  <= first_phase(run_plus);
					eor_q    <= 1'b1;
					pend_q   <= 1'b0;
					run_q    <= '0;
					colour_q <= 1'b0;
				end else begin
					run_q <= run_plus;
				end
			end
			if (cmd.emit_go) begin
				hold_valid_q <= 1'b1;
				hold_byte_q  <= cur_byte;
				hold_eor_q   <= eor_q && run_last;
				unique case (phase_q)
					PH_SP0: phase_q <= PH_SP1;
					PH_SP1: phase_q <= PH_SP2;
					PH_SP2: begin
						len_q   <= len_split;
						phase_q <= first_phase(len_split);
					end
					PH_HI:  phase_q <= PH_LO;
					PH_SHORT, PH_LO: begin
						if (pend_q) begin
							len_q    <= run_q;
							phase_q  <= first_phase(run_q);
							eor_q    <= 1'b1;
							pend_q   <= 1'b0;
							run_q    <= '0;
							colour_q <= 1'b0;
						end
					end
					default: phase_q <= PH_SHORT;
				endcase
			end
			if (cmd.flush_go) begin
				hold_valid_q <= 1'b0;
			end
			if (push) begin
				out_valid_q <= 1'b1;
				out_byte_q  <= hold_byte_q;
				out_eor_q   <= hold_eor_q;
				out_last_q  <= cmd.flush_go;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign code_byte    = out_byte_q;
	assign end_of_row   = out_eor_q;
	assign last_of_item = out_last_q;

endmodule

// File: sv/brle_ctrl.sv
// Controller state machine that sequences input, pixel scan, code emission and flush.
module brle_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  brle_pkg::brle_sts_t sts,
	output brle_pkg::brle_cmd_t cmd
);
	import brle_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_PIXEL, ST_EMIT, ST_FLUSH} state_t;

	state_t state_q;
	logic   px_done_q;

	always_comb begin
		cmd          = '0;
		in_ready     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_PIXEL: cmd.px_step = 1'b1;
			ST_EMIT:  cmd.emit_go = sts.out_free;
			ST_FLUSH: cmd.flush_go = sts.out_free || !sts.hold_valid;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			px_done_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q   <= ST_PIXEL;
						px_done_q <= 1'b0;
					end
				end
				ST_PIXEL: begin
					if (sts.chg || sts.rowend) begin
						state_q   <= ST_EMIT;
						px_done_q <= sts.rowend || sts.last_px;
					end else if (sts.last_px) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_EMIT: begin
					if (sts.out_free && sts.run_last && !sts.pend_end) begin
						state_q <= px_done_q ? ST_FLUSH : ST_PIXEL;
					end
				end
				ST_FLUSH: begin
					if (cmd.flush_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: sv/bitonal_rle_encoder.sv
// Top level of the bitonal run-length encoder.
//   Channel  Dir  Payload                                    Transfer
//   pix      in   raw_byte[7:0]                              valid & ready
//   code     out  code_byte[7:0], end_of_row, last_of_item   valid & ready
//   cfg      in   cfg_wdata[15:0] (image width)              cfg_we
// A byte is taken in the idle state and scanned pixel by pixel up to the row end or
// its last pixel; each run goes out as code bytes, and a flush releases the last one.
// The scan loop shares one pixel datapath and one code byte generator.
// Reset clears the position, run and colour and sets the width to 1.
// A stalled output register holds back code generation and so the next input transfer.
module bitonal_rle_encoder (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [brle_pkg::WIDTH_W-1:0] cfg_wdata,
	brle_in_if.sink                      pix,
	brle_out_if.source                   code
);
	import brle_pkg::*;

	brle_cmd_t cmd;
	brle_sts_t sts;

	brle_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pix.valid),
		.in_ready (pix.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	brle_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.raw_byte     (pix.raw_byte),
		.cmd          (cmd),
		.sts          (sts),
		.out_ready    (code.ready),
		.out_valid    (code.valid),
		.code_byte    (code.code_byte),
		.end_of_row   (code.end_of_row),
		.last_of_item (code.last_of_item)
	);

endmodule

// File: sv/brle_checker.sv
// Port-level assertions for the bitonal run-length encoder and their binding.
module brle_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       pix_valid,
	input logic       pix_ready,
	input logic       code_valid,
	input logic       code_ready,
	input logic [7:0] code_byte,
	input logic       end_of_row,
	input logic       last_of_item
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		code_valid && !code_ready |=> code_valid)
		else $error("Output valid dropped while stalled.");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		code_valid && !code_ready |=> $stable(code_byte) && $stable(end_of_row)
			&& $stable(last_of_item))
		else $error("Output payload changed while stalled.");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_ready |=> !pix_ready)
		else $error("Input ready right after an input transfer.");

	a_idle_last: assert property (@(posedge clk) disable iff (!arst_n)
		pix_ready && code_valid |-> last_of_item)
		else $error("Pending output while idle is not the last of its item.");

endmodule

bind bitonal_rle_encoder brle_checker u_brle_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.pix_valid    (pix.valid),
	.pix_ready    (pix.ready),
	.code_valid   (code.valid),
	.code_ready   (code.ready),
	.code_byte    (code.code_byte),
	.end_of_row   (code.end_of_row),
	.last_of_item (code.last_of_item)
);

// File: verif/brle_score_pkg.sv
// Scoreboard that predicts and checks the run-length code stream of the encoder.
`timescale 1ns / 1ps
package brle_score_pkg;
	import brle_pkg::*;

	localparam int unsigned MAX_CODES = 21;

	typedef struct {
		logic [CODE_W-1:0] code;
		logic              eor;
		logic              last_item;
	} code_exp_t;

	class rle_scoreboard;
		logic [WIDTH_W-1:0] width;
		int unsigned        column;
		int unsigned        run_len;
		bit                 colour;
		code_exp_t          expected_codes[$];
		code_exp_t          fresh[$];
		int unsigned        checked;
		int unsigned        mismatches;

		function new();
			width = 16'd1;
			column = 0;
			run_len = 0;
			colour = 1'b0;
			checked = 0;
			mismatches = 0;
		endfunction

		function void set_width(logic [WIDTH_W-1:0] w);
			width = w;
		endfunction

		function int unsigned pending();
			return expected_codes.size();
		endfunction

		function void put_code(logic [CODE_W-1:0] c);
			code_exp_t e;
			if (fresh.size() >= MAX_CODES) return;
			e.code = c;
			e.eor = 1'b0;
			e.last_item = 1'b0;
			fresh.push_back(e);
		endfunction

		function void put_run(int unsigned len);
			int unsigned rest;
			rest = len;
			while (rest >= SPLIT_LIMIT) begin
				put_code(SPLIT_BYTE);
				put_code(SPLIT_BYTE);
				put_code(ZERO_RUN);
				rest -= SPLIT_CHUNK;
			end
			if (rest < SHORT_LIMIT) begin
				put_code(8'(rest));
			end else begin
				put_code({LONG_PREFIX, 6'(rest >> 8)});
				put_code(8'(rest));
			end
		endfunction

		function void note_byte(logic [RAW_W-1:0] raw);
			int unsigned eff_width;
			int          i;
			bit          px;
			code_exp_t   e;
			fresh.delete();
			eff_width = (width == 0) ? 1 : width;
			for (i = 7; i >= 0; i--) begin
				px = raw[i];
				if (px == colour) begin
					run_len++;
				end else begin
					put_run(run_len);
					run_len = 1;
					colour = px;
				end
				column++;
				if (column >= eff_width) begin
					put_run(run_len);
					if (fresh.size() > 0) begin
						e = fresh.pop_back();
						e.eor = 1'b1;
						fresh.push_back(e);
					end
					column = 0;
					run_len = 0;
					colour = 1'b0;
					break;
				end
			end
			column &= 32'hFFFF;
			run_len &= 32'hFFFF;
			if (fresh.size() > 0) begin
				e = fresh.pop_back();
				e.last_item = 1'b1;
				fresh.push_back(e);
			end
			foreach (fresh[k]) expected_codes.push_back(fresh[k]);
		endfunction

		function void flag_mismatch(string msg);
			mismatches++;
			if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
		endfunction

		function void check_code(logic [CODE_W-1:0] code, logic eor, logic last_item);
			code_exp_t e;
			if (expected_codes.size() == 0) begin
				flag_mismatch($sformatf("unexpected code byte %02h eor=%b last=%b",
					code, eor, last_item));
				return;
			end
			e = expected_codes.pop_front();
			checked++;
			if (code !== e.code || eor !== e.eor || last_item !== e.last_item)
				flag_mismatch($sformatf("code byte %02h eor=%b last=%b, expected %02h eor=%b last=%b",
					code, eor, last_item, e.code, e.eor, e.last_item));
		endfunction
	endclass

endpackage

// File: verif/bitonal_rle_encoder_tb.sv
// Testbench of the bitonal run-length encoder: directed, long-run and random raster streams.
`timescale 1ns / 1ps
module bitonal_rle_encoder_tb;
	import brle_pkg::*;
	import brle_score_pkg::*;

	localparam int unsigned DRAIN_GAP      = 16;
	localparam int unsigned LONG_HOLD      = 300;
	localparam int unsigned WATCHDOG_LIMIT = 4000;
	localparam int unsigned PHASE_BYTES    = 42;

	typedef enum int {PAT_NOISE, PAT_WHITE, PAT_BLACK, PAT_SPECK} pattern_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_we;
	logic [WIDTH_W-1:0] cfg_wdata;

	brle_in_if  pix_if ();
	brle_out_if code_if ();

	bitonal_rle_encoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.pix       (pix_if),
		.code      (code_if)
	);

	rle_scoreboard sb = new();

	int unsigned idle_in_pct  = 0;
	int unsigned idle_out_pct = 0;
	bit          hold_req     = 1'b0;
	int unsigned hold_left    = 0;
	int unsigned quiet_cycles = 0;
	int unsigned bytes_in     = 0;
	int unsigned widths_used  = 0;
	int unsigned stretch_left = 0;
	pattern_t    stretch_kind = PAT_NOISE;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (pix_if.valid && pix_if.ready) begin
			sb.note_byte(pix_if.raw_byte);
			bytes_in++;
		end
		if (code_if.valid && code_if.ready)
			sb.check_code(code_if.code_byte, code_if.end_of_row, code_if.last_of_item);
		if ((pix_if.valid && pix_if.ready) || (code_if.valid && code_if.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		code_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				code_if.ready <= 1'b0;
			end else begin
				code_if.ready <= ($urandom_range(0, 99) >= idle_out_pct);
			end
		end
	end

	task automatic send_byte(input logic [RAW_W-1:0] b);
		while ($urandom_range(0, 99) < idle_in_pct) begin
			pix_if.valid <= 1'b0;
			@(posedge clk);
		end
		pix_if.valid <= 1'b1;
		pix_if.raw_byte <= b;
		@(posedge clk);
		while (!pix_if.ready) @(posedge clk);
	endtask

	task automatic finish_phase();
		pix_if.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_GAP) @(posedge clk);
	endtask

	task automatic write_width(input logic [WIDTH_W-1:0] w);
		cfg_we <= 1'b1;
		cfg_wdata <= w;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_width(w);
		widths_used++;
	endtask

	function automatic logic [RAW_W-1:0] pick_byte();
		if (stretch_left == 0) begin
			stretch_kind = pattern_t'($urandom_range(0, 3));
			stretch_left = $urandom_range(1, 30);
		end
		stretch_left--;
		case (stretch_kind)
			PAT_WHITE: return 8'h00;
			PAT_BLACK: return 8'hFF;
			PAT_SPECK: return ($urandom_range(0, 1) ? 8'h01 : 8'hFE) << $urandom_range(0, 7);
			default:   return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [WIDTH_W-1:0] pick_width();
		case ($urandom_range(0, 5))
			0:       return 16'd0;
			1:       return 16'hFFFF;
			2:       return 16'($urandom_range(1, 24));
			3:       return 16'($urandom_range(2, 70));
			default: return 16'($urandom_range(180, 700));
		endcase
	endfunction

	initial begin
		int unsigned in_mix[4]  = '{0, 48, 0, 19};
		int unsigned out_mix[4] = '{0, 0, 48, 19};
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		pix_if.valid <= 1'b0;
		pix_if.raw_byte <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_byte(8'h80);
		send_byte(8'h00);
		finish_phase();
		write_width(16'd8);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'hAA);
		send_byte(8'h55);
		finish_phase();
		write_width(16'd0);
		send_byte(8'hFF);
		send_byte(8'h01);
		finish_phase();
		write_width(16'd12);
		send_byte(8'hF0);
		send_byte(8'h0F);
		send_byte(8'h00);
		send_byte(8'hFF);
		finish_phase();
		write_width(16'd16);
		send_byte(8'h00);
		finish_phase();
		write_width(16'd4);
		send_byte(8'h7F);
		finish_phase();

		// Long rows with runs that need the two-byte codes.
		idle_in_pct = 19;
		idle_out_pct = 19;
		write_width(16'hFFFF);
		repeat (30) send_byte(8'hFF);
		send_byte(8'h55);
		repeat (26) send_byte(8'h00);
		send_byte(8'h80);
		finish_phase();
		write_width(16'd1);
		send_byte(8'hFF);
		finish_phase();

		for (int m = 0; m < 4; m++) begin
			for (int p = 0; p < 2; p++) begin
				idle_in_pct = in_mix[m];
				idle_out_pct = out_mix[m];
				write_width(pick_width());
				if (m == 0 && p == 0) hold_req = 1'b1;
				repeat (PHASE_BYTES) send_byte(pick_byte());
				finish_phase();
			end
		end

		$display("Encoded %0d raster bytes into %0d checked code bytes over %0d width settings,",
			bytes_in, sb.checked, widths_used);
		$display("including two-byte runs, mid-row width changes and four handshake idling mixes.");
		if (sb.mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// File: bitonal_rle_encoder.f
sv/brle_pkg.sv
sv/brle_if.sv
sv/brle_datapath.sv
sv/brle_ctrl.sv
sv/bitonal_rle_encoder.sv
sv/brle_checker.sv
verif/brle_score_pkg.sv
verif/bitonal_rle_encoder_tb.sv
